>>> rtl/planar_twist_point_advance_top_assert.svh
// Assertion macros for the planar twist point advance top level.
`ifndef PLANAR_TWIST_POINT_ADVANCE_TOP_ASSERT_SVH
`define PLANAR_TWIST_POINT_ADVANCE_TOP_ASSERT_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define PTPA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define PTPA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/ptpa_pkg.sv
// Package with constants, record types and helper functions of the point advance pipeline.
package ptpa_pkg;

  localparam int unsigned FRAC_BITS         = 16;
  localparam int unsigned CORDIC_STAGES_DEF = 16;
  localparam int unsigned ATAN_LEN          = 24;

  localparam logic [63:0] TWO_PI_Q60 = 64'h6487ED5110B4611A;
  // Two pi with twice the fraction bits of the ports, the grid of yaw_rate times duration.
  localparam logic [63:0] TWOPI_QF2 =
    (TWO_PI_Q60 + (64'd1 << (59 - 2 * FRAC_BITS))) >> (60 - 2 * FRAC_BITS);
  localparam logic [63:0] HALF_TWOPI  = TWOPI_QF2 / 2;
  localparam logic [63:0] PI_Q30      = (TWO_PI_Q60 + (64'd1 << 30)) >> 31;
  localparam logic [63:0] HALF_PI_Q30 = (TWO_PI_Q60 + (64'd1 << 31)) >> 32;
  localparam logic [31:0] GAIN_Q30    = 32'h26DD3B6A;
  localparam logic [31:0] ONE_Q30     = 32'h4000_0000;

  // Largest magnitude of the angle product is below 2^42.
  localparam logic [63:0] MAX_PROD  = 64'd1 << 42;
  localparam int unsigned MOD_STEPS = $clog2(MAX_PROD / TWOPI_QF2 + 1);

  localparam int unsigned SMALL_ANGLE = ((1 << FRAC_BITS) + 500) / 1000;

  // Reciprocals for the narrow divisions by six and by twenty-four.
  localparam int unsigned RECIP_SHIFT = 16;
  localparam logic [13:0] RECIP_6     = 14'd10923;
  localparam logic [11:0] RECIP_24    = 12'd2731;

  localparam int unsigned MOD_W  = 43;
  localparam int unsigned Z_W    = 34;
  localparam int unsigned DIV_W  = 51;
  localparam int unsigned Q_W    = 33;
  localparam int unsigned D_W    = 26;
  localparam int unsigned FAC_W  = 33;
  localparam int unsigned TRIG_W = 35;

  localparam logic [31:0] ATAN_Q30 [ATAN_LEN] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
    32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
    32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
    32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F
  };

  // Item fields that ride along the whole pipeline.
  typedef struct packed {
    logic signed [19:0] sx;
    logic signed [19:0] sy;
    logic signed [19:0] vx;
    logic signed [19:0] vy;
    logic signed [19:0] ez;
    logic        [20:0] dur;
    logic signed [26:0] a;
    logic               near_zero;
    logic        [10:0] a2;
    logic        [30:0] sc_small;
    logic        [29:0] c_fac;
  } side_t;

  typedef struct packed {
    logic [MOD_W-1:0] rem;
    logic             neg;
    side_t            side;
  } mod_t;

  typedef struct packed {
    logic signed [Z_W-1:0] x;
    logic signed [Z_W-1:0] y;
    logic signed [Z_W-1:0] z;
    logic                  neg;
    side_t                 side;
  } cordic_t;

  typedef struct packed {
    logic        [DIV_W-1:0]  rem_s;
    logic        [DIV_W-1:0]  rem_c;
    logic        [Q_W-1:0]    q_s;
    logic        [Q_W-1:0]    q_c;
    logic                     neg_s;
    logic                     neg_c;
    logic        [D_W-1:0]    d;
    logic signed [TRIG_W-1:0] sn;
    logic signed [TRIG_W-1:0] cs;
    logic signed [52:0]       cc_prod;
    side_t                    side;
  } div_t;

  // Right shift that rounds to nearest, ties away from zero.
  function automatic logic signed [63:0] rnd_shr(input logic signed [63:0] v,
                                                 input int unsigned s);
    logic [63:0] m;
    m = v[63] ? 64'(-v) : 64'(v);
    m = (m + (64'd1 << (s - 1))) >> s;
    return v[63] ? -$signed(m) : $signed(m);
  endfunction

  // Saturates to the 20-bit position range.
  function automatic logic signed [19:0] clamp_pos(input logic signed [63:0] v);
    logic signed [19:0] r;
    if (v > 64'sd524287) begin
      r = 20'sd524287;
    end else if (v < -64'sd524288) begin
      r = -20'sd524288;
    end else begin
      r = 20'(v);
    end
    return r;
  endfunction

  // Limits a quotient magnitude to two in Q30 and applies its sign.
  function automatic logic signed [FAC_W-1:0] sat_fac(input logic [Q_W-1:0] q,
                                                      input logic neg);
    logic [FAC_W-1:0] m;
    m = (q > (Q_W'(1) << 31)) ? (FAC_W'(1) << 31) : FAC_W'(q);
    return neg ? -$signed(m) : $signed(m);
  endfunction

endpackage

>>> rtl/ptpa_mod_cell.sv
// One restoring step of the angle reduction modulo two pi.
module ptpa_mod_cell #(
  parameter int unsigned SHIFT = 0
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  ptpa_pkg::mod_t data_i,
  output logic          valid_o,
  output ptpa_pkg::mod_t data_o
);
  import ptpa_pkg::*;

  localparam logic [MOD_W-1:0] STEP = MOD_W'(TWOPI_QF2 << SHIFT);

  mod_t data_d, data_q;
  logic valid_q;

  always_comb begin
    data_d = data_i;
    if (data_i.rem >= STEP) begin
      data_d.rem = data_i.rem - STEP;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

>>> rtl/ptpa_cordic_cell.sv
// One rotation step of the sine and cosine CORDIC.
module ptpa_cordic_cell #(
  parameter int unsigned STAGE = 0
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  ptpa_pkg::cordic_t data_i,
  output logic             valid_o,
  output ptpa_pkg::cordic_t data_o
);
  import ptpa_pkg::*;

  localparam logic signed [Z_W-1:0] ATAN = Z_W'(ATAN_Q30[STAGE]);

  cordic_t data_d, data_q;
  logic valid_q;
  logic signed [Z_W-1:0] dx, dy;

  always_comb begin
    data_d = data_i;
    dx = data_i.y >>> STAGE;
    dy = data_i.x >>> STAGE;
    if (!data_i.z[Z_W-1]) begin
      data_d.x = data_i.x - dx;
      data_d.y = data_i.y + dy;
      data_d.z = data_i.z - ATAN;
    end else begin
      data_d.x = data_i.x + dx;
      data_d.y = data_i.y - dy;
      data_d.z = data_i.z + ATAN;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

>>> rtl/ptpa_div_cell.sv
// One quotient bit of the two restoring dividers for the sinc and versine factors.
module ptpa_div_cell #(
  parameter int unsigned K = 0
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  ptpa_pkg::div_t data_i,
  output logic          valid_o,
  output ptpa_pkg::div_t data_o
);
  import ptpa_pkg::*;

  localparam int unsigned CMP_W = ((DIV_W > D_W + K) ? DIV_W : D_W + K) + 1;

  div_t data_d, data_q;
  logic valid_q;
  logic [CMP_W-1:0] step, rs, rc;

  always_comb begin
    data_d = data_i;
    step   = CMP_W'(data_i.d) << K;
    rs     = CMP_W'(data_i.rem_s);
    rc     = CMP_W'(data_i.rem_c);
    if (rs >= step) begin
      data_d.rem_s  = DIV_W'(rs - step);
      data_d.q_s[K] = 1'b1;
    end
    if (rc >= step) begin
      data_d.rem_c  = DIV_W'(rc - step);
      data_d.q_c[K] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

>>> rtl/planar_twist_point_advance_top.sv
// Top level of the planar twist point advance pipeline.
//
// The block moves a foot point against a constant body twist held for a given
// duration. Each input beat on the slave stream carries one start point, one
// velocity, one yaw rate and one duration; each output beat on the master stream
// carries the advanced point, saturated to the position range.
// The datapath is a fixed pipeline built from rows of identical cells: a chain of
// reduction cells that folds the angle into one turn, a chain of CORDIC rotation
// cells for sine and cosine, and a chain of divider cells, one quotient bit each,
// for the sinc and versine factors. One beat enters per cycle while the output does
// not stall, so the sustained rate is one item per clock cycle. The number of
// CORDIC stages that run is CORDIC_STAGES, at most 24, and 16 by default.
// Reset clears every valid flag, so the pipeline comes up empty with
// m_axis_tvalid_o low; payload registers are not reset. When the receiver holds
// m_axis_tready_i low while a result waits, the whole pipeline freezes and
// s_axis_tready_o drops in the same cycle; no beat is lost or repeated.
`include "planar_twist_point_advance_top_assert.svh"

module planar_twist_point_advance_top #(
  parameter int unsigned CORDIC_STAGES = ptpa_pkg::CORDIC_STAGES_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // Fields from bit 0 up: start_x[19:0], start_y[39:20], start_z[59:40], vel_x[79:60],
  // vel_y[99:80], vel_z[119:100], yaw_rate[141:120], duration[162:142], zero fill.
  input  logic [167:0] s_axis_tdata_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // Fields from bit 0 up: end_x[19:0], end_y[39:20], end_z[59:40], zero fill.
  output logic [63:0]  m_axis_tdata_o
);
  import ptpa_pkg::*;

  localparam int unsigned NSTG      = (CORDIC_STAGES > ATAN_LEN) ? ATAN_LEN : CORDIC_STAGES;
  localparam int unsigned DIV_CELLS = Q_W;

  localparam logic signed [Z_W-1:0] HALF_PI_Z = Z_W'(HALF_PI_Q30);
  localparam logic signed [Z_W-1:0] PI_Z      = Z_W'(PI_Q30);
  localparam logic signed [Z_W-1:0] FOLD_LIM  = HALF_PI_Z + Z_W'(2);
  localparam logic signed [35:0]    TWOPI_R   = 36'(TWOPI_QF2);
  localparam logic signed [35:0]    HALF_R    = 36'(HALF_TWOPI);
  localparam logic [D_W-1:0]        SMALL_D   = D_W'(SMALL_ANGLE);

  // The whole pipeline advances unless a finished beat waits at the output.
  logic en;
  assign en              = !m_axis_tvalid_o || m_axis_tready_i;
  assign s_axis_tready_o = en;

  // Input unpacking.
  logic signed [19:0] in_sx, in_sy, in_sz, in_vx, in_vy, in_vz;
  logic signed [21:0] in_wz;
  logic        [20:0] in_dur;

  assign in_sx  = s_axis_tdata_i[19:0];
  assign in_sy  = s_axis_tdata_i[39:20];
  assign in_sz  = s_axis_tdata_i[59:40];
  assign in_vx  = s_axis_tdata_i[79:60];
  assign in_vy  = s_axis_tdata_i[99:80];
  assign in_vz  = s_axis_tdata_i[119:100];
  assign in_wz  = s_axis_tdata_i[141:120];
  assign in_dur = s_axis_tdata_i[162:142];

  // Stage 1: angle product and vertical travel.
  logic               s1_valid_q;
  logic signed [42:0] s1_p_q;
  logic signed [41:0] s1_vzd_q;
  logic signed [19:0] s1_sx_q, s1_sy_q, s1_sz_q, s1_vx_q, s1_vy_q;
  logic        [20:0] s1_dur_q;
  logic signed [42:0] s1_p_d;
  logic signed [41:0] s1_vzd_d;

  always_comb begin
    s1_p_d   = in_wz * $signed({1'b0, in_dur});
    s1_vzd_d = in_vz * $signed({1'b0, in_dur});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (en) begin
      s1_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_p_q   <= s1_p_d;
      s1_vzd_q <= s1_vzd_d;
      s1_sx_q  <= in_sx;
      s1_sy_q  <= in_sy;
      s1_sz_q  <= in_sz;
      s1_vx_q  <= in_vx;
      s1_vy_q  <= in_vy;
      s1_dur_q <= in_dur;
    end
  end

  // Stage 2: full angle, end_z and the magnitude that enters the reduction chain.
  mod_t mod_chain [MOD_STEPS+1];
  logic mod_v     [MOD_STEPS+1];
  mod_t mod_in_d;
  logic mod_in_valid_q;
  mod_t mod_in_q;

  always_comb begin
    mod_in_d              = '0;
    mod_in_d.neg          = s1_p_q[42];
    mod_in_d.rem          = s1_p_q[42] ? MOD_W'(-s1_p_q) : MOD_W'(s1_p_q);
    mod_in_d.side.sx      = s1_sx_q;
    mod_in_d.side.sy      = s1_sy_q;
    mod_in_d.side.vx      = s1_vx_q;
    mod_in_d.side.vy      = s1_vy_q;
    mod_in_d.side.dur     = s1_dur_q;
    mod_in_d.side.a       = 27'(rnd_shr(64'(s1_p_q), FRAC_BITS));
    mod_in_d.side.ez      = clamp_pos(64'(s1_sz_q) - rnd_shr(64'(s1_vzd_q), FRAC_BITS));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mod_in_valid_q <= 1'b0;
    end else if (en) begin
      mod_in_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      mod_in_q <= mod_in_d;
    end
  end

  assign mod_chain[0] = mod_in_q;
  assign mod_v[0]     = mod_in_valid_q;

  // Reduction chain: one multiple of two pi per cell, largest first.
  for (genvar k = 0; k < MOD_STEPS; k++) begin : g_mod
    ptpa_mod_cell #(.SHIFT(MOD_STEPS - 1 - k)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (mod_v[k]),
      .data_i  (mod_chain[k]),
      .valid_o (mod_v[k+1]),
      .data_o  (mod_chain[k+1])
    );
  end

  // Stage A: signed remainder moved into one turn around zero, small-angle square.
  logic               ra_valid_q;
  logic signed [35:0] ra_r_q;
  side_t              ra_side_q;
  logic signed [35:0] ra_r_d, ra_rs;
  side_t              ra_side_d;
  logic        [26:0] ra_am;
  logic        [13:0] ra_sq;

  always_comb begin
    ra_rs = $signed({1'b0, mod_chain[MOD_STEPS].rem[34:0]});
    if (mod_chain[MOD_STEPS].neg) begin
      ra_rs = -ra_rs;
    end
    if (ra_rs >= HALF_R) begin
      ra_r_d = ra_rs - TWOPI_R;
    end else if (ra_rs < -HALF_R) begin
      ra_r_d = ra_rs + TWOPI_R;
    end else begin
      ra_r_d = ra_rs;
    end
    ra_side_d           = mod_chain[MOD_STEPS].side;
    ra_am               = ra_side_d.a[26] ? 27'(-ra_side_d.a) : 27'(ra_side_d.a);
    ra_side_d.near_zero = (ra_am < 27'(SMALL_ANGLE));
    ra_sq               = 14'(ra_am[6:0]) * 14'(ra_am[6:0]);
    ra_side_d.a2        = 11'((ra_sq + 14'd2) >> 2);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ra_valid_q <= 1'b0;
    end else if (en) begin
      ra_valid_q <= mod_v[MOD_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ra_r_q    <= ra_r_d;
      ra_side_q <= ra_side_d;
    end
  end

  // Stage B: angle in Q30 folded to the right half plane, small-angle factors.
  cordic_t cor_chain [NSTG+1];
  logic    cor_v     [NSTG+1];
  cordic_t cor_in_d, cor_in_q;
  logic    cor_in_valid_q;
  logic signed [Z_W-1:0] rb_z;
  logic [24:0] rb_m6;
  logic [23:0] rb_m24;

  always_comb begin
    rb_z          = Z_W'(rnd_shr(64'(ra_r_q), 2));
    cor_in_d      = '0;
    cor_in_d.side = ra_side_q;
    cor_in_d.x    = Z_W'(GAIN_Q30);
    cor_in_d.y    = '0;
    if (rb_z > HALF_PI_Z) begin
      cor_in_d.z   = rb_z - PI_Z;
      cor_in_d.neg = 1'b1;
    end else if (rb_z < -HALF_PI_Z) begin
      cor_in_d.z   = rb_z + PI_Z;
      cor_in_d.neg = 1'b1;
    end else begin
      cor_in_d.z   = rb_z;
      cor_in_d.neg = 1'b0;
    end
    rb_m6  = 25'(ra_side_q.a2 + 11'd3) * 25'(RECIP_6);
    rb_m24 = 24'(ra_side_q.a2 + 11'd12) * 24'(RECIP_24);
    cor_in_d.side.sc_small = 31'(ONE_Q30) - 31'(rb_m6 >> RECIP_SHIFT);
    cor_in_d.side.c_fac    = 30'(ONE_Q30 >> 1) - 30'(rb_m24 >> RECIP_SHIFT);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cor_in_valid_q <= 1'b0;
    end else if (en) begin
      cor_in_valid_q <= ra_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cor_in_q <= cor_in_d;
    end
  end

  assign cor_chain[0] = cor_in_q;
  assign cor_v[0]     = cor_in_valid_q;

  for (genvar i = 0; i < NSTG; i++) begin : g_cordic
    ptpa_cordic_cell #(.STAGE(i)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (cor_v[i]),
      .data_i  (cor_chain[i]),
      .valid_o (cor_v[i+1]),
      .data_o  (cor_chain[i+1])
    );
  end

  // Stage C: sine and cosine out of the fold, dividend magnitudes with half divisor.
  div_t div_chain [DIV_CELLS+1];
  logic div_v     [DIV_CELLS+1];
  div_t div_in_d, div_in_q;
  logic div_in_valid_q;
  cordic_t             rc;
  logic [Z_W-1:0]      rc_ym;
  logic signed [35:0]  rc_nc;
  logic [35:0]         rc_ncm;
  logic signed [21:0]  rc_a30;

  always_comb begin
    rc              = cor_chain[NSTG];
    div_in_d        = '0;
    div_in_d.side   = rc.side;
    div_in_d.sn     = rc.neg ? -TRIG_W'(rc.y) : TRIG_W'(rc.y);
    div_in_d.cs     = rc.neg ? -TRIG_W'(rc.x) : TRIG_W'(rc.x);
    div_in_d.d      = rc.side.a[26] ? D_W'(-rc.side.a) : D_W'(rc.side.a);
    rc_ym           = rc.y[Z_W-1] ? Z_W'(-rc.y) : Z_W'(rc.y);
    rc_nc           = 36'(ONE_Q30) - 36'(div_in_d.cs);
    rc_ncm          = rc_nc[35] ? 36'(-rc_nc) : 36'(rc_nc);
    div_in_d.rem_s  = (DIV_W'(rc_ym) << FRAC_BITS) + DIV_W'(div_in_d.d >> 1);
    div_in_d.rem_c  = (DIV_W'(rc_ncm) << FRAC_BITS) + DIV_W'(div_in_d.d >> 1);
    div_in_d.neg_s  = div_in_d.sn[TRIG_W-1] ^ rc.side.a[26];
    div_in_d.neg_c  = rc_nc[35] ^ rc.side.a[26];
    rc_a30          = {rc.side.a[7:0], 14'd0};
    div_in_d.cc_prod = rc_a30 * $signed({1'b0, rc.side.c_fac});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_in_valid_q <= 1'b0;
    end else if (en) begin
      div_in_valid_q <= cor_v[NSTG];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      div_in_q <= div_in_d;
    end
  end

  assign div_chain[0] = div_in_q;
  assign div_v[0]     = div_in_valid_q;

  // Divider chain: quotient bits from the top one down; the top bit flags overflow.
  for (genvar k = 0; k < DIV_CELLS; k++) begin : g_div
    ptpa_div_cell #(.K(DIV_CELLS - 1 - k)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (div_v[k]),
      .data_i  (div_chain[k]),
      .valid_o (div_v[k+1]),
      .data_o  (div_chain[k+1])
    );
  end

  // Stage D: pick the series or the quotient, limited to two.
  logic                     fd_valid_q;
  logic signed [FAC_W-1:0]  fd_sc_q, fd_cc_q;
  logic signed [TRIG_W-1:0] fd_sn_q, fd_cs_q;
  side_t                    fd_side_q;
  logic signed [FAC_W-1:0]  fd_sc_d, fd_cc_d;
  div_t                     rd;

  always_comb begin
    rd = div_chain[DIV_CELLS];
    if (rd.side.near_zero) begin
      fd_sc_d = FAC_W'(rd.side.sc_small);
      fd_cc_d = FAC_W'(rnd_shr(64'(rd.cc_prod), 30));
    end else begin
      fd_sc_d = sat_fac(rd.q_s, rd.neg_s);
      fd_cc_d = sat_fac(rd.q_c, rd.neg_c);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fd_valid_q <= 1'b0;
    end else if (en) begin
      fd_valid_q <= div_v[DIV_CELLS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      fd_sc_q   <= fd_sc_d;
      fd_cc_q   <= fd_cc_d;
      fd_sn_q   <= rd.sn;
      fd_cs_q   <= rd.cs;
      fd_side_q <= rd.side;
    end
  end

  // Stage E: translation and rotation products.
  logic               pe_valid_q;
  logic signed [55:0] pe_vxs_q, pe_vyc_q, pe_vxc_q, pe_vys_q;
  logic signed [55:0] pe_csx_q, pe_sny_q, pe_csy_q, pe_snx_q;
  side_t              pe_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pe_valid_q <= 1'b0;
    end else if (en) begin
      pe_valid_q <= fd_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pe_vxs_q  <= fd_side_q.vx * fd_sc_q;
      pe_vyc_q  <= fd_side_q.vy * fd_cc_q;
      pe_vxc_q  <= fd_side_q.vx * fd_cc_q;
      pe_vys_q  <= fd_side_q.vy * fd_sc_q;
      pe_csx_q  <= fd_cs_q * fd_side_q.sx;
      pe_sny_q  <= fd_sn_q * fd_side_q.sy;
      pe_csy_q  <= fd_cs_q * fd_side_q.sy;
      pe_snx_q  <= fd_sn_q * fd_side_q.sx;
      pe_side_q <= fd_side_q;
    end
  end

  // Stage F: translation rates back in port format, rotated start point in Q46.
  logic               sf_valid_q;
  logic signed [23:0] sf_tx_q, sf_ty_q;
  logic signed [56:0] sf_rx_q, sf_ry_q;
  side_t              sf_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sf_valid_q <= 1'b0;
    end else if (en) begin
      sf_valid_q <= pe_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sf_tx_q   <= 24'(rnd_shr(64'(pe_vxs_q) + 64'(pe_vyc_q), 30));
      sf_ty_q   <= 24'(rnd_shr(64'(pe_vxc_q) - 64'(pe_vys_q), 30));
      sf_rx_q   <= 57'(pe_csx_q) + 57'(pe_sny_q);
      sf_ry_q   <= 57'(pe_csy_q) - 57'(pe_snx_q);
      sf_side_q <= pe_side_q;
    end
  end

  // Stage G: translation over the duration.
  logic               sg_valid_q;
  logic signed [45:0] sg_dx_q, sg_dy_q;
  logic signed [56:0] sg_rx_q, sg_ry_q;
  logic signed [19:0] sg_ez_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sg_valid_q <= 1'b0;
    end else if (en) begin
      sg_valid_q <= sf_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sg_dx_q <= $signed({1'b0, sf_side_q.dur}) * sf_tx_q;
      sg_dy_q <= $signed({1'b0, sf_side_q.dur}) * sf_ty_q;
      sg_rx_q <= sf_rx_q;
      sg_ry_q <= sf_ry_q;
      sg_ez_q <= sf_side_q.ez;
    end
  end

  // Stage H: output register.
  logic               out_valid_q;
  logic signed [19:0] out_x_q, out_y_q, out_z_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= sg_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_x_q <= clamp_pos(rnd_shr(64'(sg_rx_q) - (64'(sg_dx_q) <<< (30 - FRAC_BITS)), 30));
      out_y_q <= clamp_pos(rnd_shr(64'(sg_ry_q) + (64'(sg_dy_q) <<< (30 - FRAC_BITS)), 30));
      out_z_q <= sg_ez_q;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {4'd0, out_z_q, out_y_q, out_x_q};

  // A beat offered while the output stalls must not be taken.
  `PTPA_ASSERT_NOW(a_stall_blocks_input, m_axis_tvalid_o && !m_axis_tready_i, !s_axis_tready_o, "input taken during output stall")
  // An accepted beat always shows up in the first pipeline stage.
  `PTPA_ASSERT_NEXT(a_accept_enters, s_axis_tvalid_i && s_axis_tready_o, s1_valid_q, "accepted beat lost at entry")
  // The folded CORDIC angle stays within a quarter turn.
  `PTPA_ASSERT_NOW(a_fold_range, cor_in_valid_q, (cor_in_q.z <= FOLD_LIM) && (cor_in_q.z >= -FOLD_LIM), "CORDIC angle out of range")
  // The divided factors are only used for angles at or above the small-angle bound.
  `PTPA_ASSERT_NOW(a_div_bound, div_v[DIV_CELLS] && !div_chain[DIV_CELLS].side.near_zero, div_chain[DIV_CELLS].d >= SMALL_D, "division by a small angle")

endmodule

>>> dv/tb_planar_twist_point_advance_top.sv
// Self-checking stream testbench for the planar twist point advance block.
module tb_planar_twist_point_advance_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ptpa_pkg::*;

  localparam int unsigned STAGES      = CORDIC_STAGES_DEF;
  localparam int unsigned LATENCY     = 51 + STAGES;
  localparam int unsigned STALL_LIMIT = 5000;

  // One foot point with the twist that moves it; drain_first holds it back until
  // every result already owed by the block has come out.
  typedef struct {
    logic signed [19:0] sx, sy, sz, vx, vy, vz;
    logic signed [21:0] wz;
    logic        [20:0] dur;
    bit                 drain_first;
  } foot_move_t;

  typedef struct {
    logic signed [19:0] ex, ey, ez;
  } foot_end_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid_i = 1'b0;
  logic         s_axis_tready_o;
  logic [167:0] s_axis_tdata_i = '0;
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i = 1'b0;
  logic [63:0]  m_axis_tdata_o;

  foot_move_t moves_q[$];
  foot_end_t  ends_q[$];
  foot_move_t cur_move;
  int unsigned errors = 0;
  int unsigned quiet_cycles = 0;
  int unsigned send_gap = 0;
  int unsigned recv_gap = 0;
  bit          calm = 1'b0;
  bit          stim_done = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  planar_twist_point_advance_top u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  function automatic longint round_shift(longint v, int unsigned s);
    longint m;
    if (s == 0) return v;
    m = (v < 0) ? -v : v;
    m = (m + (64'sd1 <<< (s - 1))) >>> s;
    return (v < 0) ? -m : m;
  endfunction

  function automatic longint round_div(longint n, longint d);
    longint mn, md, q;
    mn = (n < 0) ? -n : n;
    md = (d < 0) ? -d : d;
    if (md == 0) return 0;
    q = (mn + md / 2) / md;
    return ((n < 0) != (d < 0)) ? -q : q;
  endfunction

  function automatic longint limit(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // Exact planar rigid-motion advance of one foot point, bit for bit with the block.
  function automatic foot_end_t advance_foot(foot_move_t m);
    longint sx, sy, sz, vx, vy, vz, wz, dur;
    longint prod, ang, twopi, rem, z, x, y, dx, dy, pi30, half30, t;
    longint sn, cs, sc, cc, tx, ty, rx, ry, a2, a30;
    bit flip;
    foot_end_t r;
    sx = m.sx; sy = m.sy; sz = m.sz; vx = m.vx; vy = m.vy; vz = m.vz;
    wz = m.wz; dur = longint'(m.dur);
    prod  = wz * dur;
    ang   = round_shift(prod, FRAC_BITS);
    t     = longint'(TWO_PI_Q60);
    twopi = round_shift(t, 60 - 2 * FRAC_BITS);
    rem   = prod % twopi;
    if (rem >= twopi / 2) rem -= twopi;
    else if (rem < -(twopi / 2)) rem += twopi;
    // Angle into Q30, then fold into the half turn the rotation stages cover.
    z      = (2 * FRAC_BITS >= 30) ? round_shift(rem, 2 * FRAC_BITS - 30)
                                   : rem * (64'sd1 <<< (30 - 2 * FRAC_BITS));
    pi30   = round_shift(t, 31);
    half30 = round_shift(t, 32);
    flip   = 1'b0;
    if (z > half30) begin
      z -= pi30; flip = 1'b1;
    end else if (z < -half30) begin
      z += pi30; flip = 1'b1;
    end
    x = longint'(GAIN_Q30);
    y = 0;
    for (int i = 0; i < STAGES && i < ATAN_LEN; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(ATAN_Q30[i]);
      end else begin
        x += dx; y -= dy; z += longint'(ATAN_Q30[i]);
      end
    end
    sn = flip ? -y : y;
    cs = flip ? -x : x;
    if (((ang < 0) ? -ang : ang) < longint'(SMALL_ANGLE)) begin
      // Near zero angle the sinc and versine terms come from a short series.
      a2  = round_shift(ang * ang, 2 * FRAC_BITS - 30);
      a30 = ang * (64'sd1 <<< (30 - FRAC_BITS));
      sc  = (64'sd1 <<< 30) - round_div(a2, 6);
      cc  = round_shift(a30 * ((64'sd1 <<< 29) - round_div(a2, 24)), 30);
    end else begin
      sc = round_div(sn * (64'sd1 <<< FRAC_BITS), ang);
      cc = round_div(((64'sd1 <<< 30) - cs) * (64'sd1 <<< FRAC_BITS), ang);
    end
    sc = limit(sc, -(64'sd2 <<< 30), 64'sd2 <<< 30);
    cc = limit(cc, -(64'sd2 <<< 30), 64'sd2 <<< 30);
    tx = round_shift(vx * sc + vy * cc, 30);
    ty = round_shift(vx * cc - vy * sc, 30);
    rx = cs * sx + sn * sy;
    ry = cs * sy - sn * sx;
    r.ex = 20'(limit(round_shift(rx - dur * tx * (64'sd1 <<< (30 - FRAC_BITS)), 30),
                     -524288, 524287));
    r.ey = 20'(limit(round_shift(ry + dur * ty * (64'sd1 <<< (30 - FRAC_BITS)), 30),
                     -524288, 524287));
    r.ez = 20'(limit(sz - round_shift(vz * dur, FRAC_BITS), -524288, 524287));
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [19:0] got, logic [19:0] want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, $signed(got),
             $signed(want), $realtime);
    errors++;
  endtask

  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (calm || roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Input side: accept at the rising edge, present the next beat at the falling edge.
  bit took;
  always @(posedge clk_i) begin
    took = 1'b0;
    if (rst_ni && s_axis_tvalid_i && s_axis_tready_o) begin
      ends_q.push_back(advance_foot(cur_move));
      took = 1'b1;
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni && (!s_axis_tvalid_i || took)) begin
      if (send_gap > 0) begin
        send_gap--;
        s_axis_tvalid_i <= 1'b0;
      end else if (moves_q.size() > 0 && !(moves_q[0].drain_first && ends_q.size() > 0)) begin
        cur_move = moves_q.pop_front();
        s_axis_tdata_i <= {5'b0, cur_move.dur, cur_move.wz, cur_move.vz, cur_move.vy,
                           cur_move.vx, cur_move.sz, cur_move.sy, cur_move.sx};
        s_axis_tvalid_i <= 1'b1;
        send_gap = pick_gap();
      end else begin
        s_axis_tvalid_i <= 1'b0;
      end
    end
  end

  // Output side: random back pressure, changed at the falling edge.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (recv_gap > 0) begin
        recv_gap--;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= 1'b1;
        recv_gap = ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
      end
      if ($urandom_range(0, 299) == 0) calm = !calm;
    end
  end

  // Checker and watchdog.
  always @(posedge clk_i) begin
    foot_end_t want;
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        if (ends_q.size() == 0) begin
          $display("UNEXPECTED result beat at %0t", $realtime);
          errors++;
        end else begin
          want = ends_q.pop_front();
          if (m_axis_tdata_o[19:0] !== want.ex)
            report_mismatch("end_x", m_axis_tdata_o[19:0], want.ex);
          if (m_axis_tdata_o[39:20] !== want.ey)
            report_mismatch("end_y", m_axis_tdata_o[39:20], want.ey);
          if (m_axis_tdata_o[59:40] !== want.ez)
            report_mismatch("end_z", m_axis_tdata_o[59:40], want.ez);
          if (m_axis_tdata_o[63:60] !== 4'b0)
            report_mismatch("fill", 20'(m_axis_tdata_o[63:60]), 20'd0);
        end
      end
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i) ||
          (moves_q.size() == 0 && ends_q.size() == 0 && !s_axis_tvalid_i)) begin
        quiet_cycles = 0;
      end else if (++quiet_cycles >= STALL_LIMIT) begin
        $display("planar_twist_point_advance_top verification failed");
        $finish;
      end
    end
  end

  function automatic foot_move_t make_move(int sx, int sy, int sz, int vx, int vy, int vz,
                                           int wz, int dur);
    foot_move_t m;
    m.sx = 20'(sx); m.sy = 20'(sy); m.sz = 20'(sz);
    m.vx = 20'(vx); m.vy = 20'(vy); m.vz = 20'(vz);
    m.wz = 22'(wz); m.dur = 21'(dur);
    m.drain_first = 1'b0;
    return m;
  endfunction

  function automatic int srand(int unsigned mag);
    return int'($urandom_range(0, 2 * mag)) - int'(mag);
  endfunction

  function automatic foot_move_t random_move();
    foot_move_t m;
    int unsigned kind;
    kind = $urandom_range(0, 9);
    if (kind < 5) begin
      // Typical gait: points within half a meter, moderate twist, short steps.
      m = make_move(srand(32768), srand(32768), srand(32768), srand(65536), srand(65536),
                    srand(65536), srand(262144), $urandom_range(0, 131072));
    end else if (kind < 7) begin
      // Angle near the series/division boundary, either sign.
      m = make_move(srand(524287), srand(524287), srand(524287), srand(524287),
                    srand(524287), srand(524287), srand(200), $urandom_range(0, 65536));
    end else begin
      // Anything the fields allow.
      m = make_move($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                    $urandom, $urandom);
    end
    return m;
  endfunction

  initial begin
    foot_move_t m;
    // Directed beats: zero and extreme fields, boundary angles, saturation.
    moves_q.push_back(make_move(0, 0, 0, 0, 0, 0, 0, 0));
    moves_q.push_back(make_move(524287, -524288, 524287, 524287, -524288, 524287,
                                2097151, 2097151));
    moves_q.push_back(make_move(-524288, 524287, -524288, -524288, 524287, -524288,
                                -2097152, 2097151));
    moves_q.push_back(make_move(65536, 0, 0, 65536, 0, 0, 0, 65536));
    moves_q.push_back(make_move(65536, 65536, 0, 65536, 65536, 65536, 65, 65536));
    moves_q.push_back(make_move(65536, 65536, 0, 65536, 65536, 65536, 66, 65536));
    moves_q.push_back(make_move(65536, 65536, 0, 65536, 65536, 65536, -65, 65536));
    moves_q.push_back(make_move(65536, 65536, 0, 65536, 65536, 65536, -66, 65536));
    moves_q.push_back(make_move(32768, -32768, 0, -65536, 65536, 0, 1, 1));
    moves_q.push_back(make_move(32768, 32768, 0, 0, 0, 0, 205887, 65536));
    moves_q.push_back(make_move(32768, 32768, 0, 0, 0, 0, 102944, 65536));
    moves_q.push_back(make_move(32768, 32768, 0, 0, 0, 0, -205887, 65536));
    moves_q.push_back(make_move(32768, 32768, 0, 0, 0, 0, 411775, 65536));
    moves_q.push_back(make_move(100000, -200000, 300000, 524287, 524287, 524287,
                                0, 1048576));
    moves_q.push_back(make_move(0, 0, 524287, 0, 0, -524288, 0, 1048576));
    moves_q.push_back(make_move(0, 0, -524288, 0, 0, 524287, 0, 1048576));
    moves_q.push_back(make_move(0, 0, 0, 524287, 0, 0, 131072, 1048577));
    moves_q.push_back(make_move(1000, 2000, 3000, 4000, 5000, 6000, 2097151, 1));
    moves_q.push_back(make_move(1000, 2000, 3000, 4000, 5000, 6000, -1, 2097151));
    for (int i = 0; i < 1800; i++) begin
      m = random_move();
      m.drain_first = (i == 600 || i == 1300);
      moves_q.push_back(m);
    end

    repeat (4) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    wait (moves_q.size() == 0);
    @(negedge clk_i);
    wait (!s_axis_tvalid_i && ends_q.size() == 0);
    repeat (LATENCY + 30) @(posedge clk_i);
    if (errors == 0) begin
      $display("planar_twist_point_advance_top verification clean");
    end else begin
      $display("planar_twist_point_advance_top verification failed");
    end
    $finish;
  end

endmodule

>>> planar_twist_point_advance_top.f
+incdir+rtl
rtl/ptpa_pkg.sv
rtl/ptpa_mod_cell.sv
rtl/ptpa_cordic_cell.sv
rtl/ptpa_div_cell.sv
rtl/planar_twist_point_advance_top.sv
dv/tb_planar_twist_point_advance_top.sv
